// ----- rtl/afom_pkg.sv -----
// Shared types and constants of the aliasing fold overlap map.
// Used by the top level and by its port checker; no dependencies.
package afom_pkg;

    // configuration register widths and indexes
    localparam int CUT_W   = 16;
    localparam int FF_W    = 4;
    localparam int AX_W    = 2;
    localparam int EX_W    = 8;
    localparam int EY_W    = 8;
    localparam int EZ_W    = 7;
    localparam int CFG_AW  = 3;
    localparam int CFG_DW  = 16;

    localparam logic [CFG_AW-1:0] REG_CUTOFF = 3'd0;
    localparam logic [CFG_AW-1:0] REG_FOLD   = 3'd1;
    localparam logic [CFG_AW-1:0] REG_AXIS   = 3'd2;
    localparam logic [CFG_AW-1:0] REG_EXT_X  = 3'd3;
    localparam logic [CFG_AW-1:0] REG_EXT_Y  = 3'd4;
    localparam logic [CFG_AW-1:0] REG_EXT_Z  = 3'd5;

    // stream words
    localparam int SAMP_W     = 16;
    localparam int IN_DATA_W  = 16;
    localparam int CNT_W      = 4;
    localparam int GF_W       = 9;
    localparam int OT_MASK_BIT = 0;
    localparam int OT_CNT_LSB  = 1;
    localparam int OT_GF_LSB   = 5;
    localparam int OT_DATA_W   = 16;
    localparam int OT_PAD_W    = OT_DATA_W - OT_GF_LSB - GF_W;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EMIT = 1'b1;

    // geometry arithmetic
    localparam int PLANE_W  = EX_W + EY_W;
    localparam int TOT_W    = PLANE_W + EZ_W;
    localparam int GN_W     = CNT_W + 9;
    localparam int RECIP_W  = 19;
    localparam int RECIP_SH = 19;
    localparam int PROD_W   = GN_W + RECIP_W;

    typedef enum logic [AX_W-1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z,
        AXIS_NONE
    } t_axis;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PLANE,
        S_TOTAL,
        S_CLAMP,
        S_DIVX,
        S_DIVY,
        S_DIVL,
        S_SEG,
        S_DIVC,
        S_EXEC,
        S_READ,
        S_GF,
        S_OUT
    } t_state;

    // ceil(2^19 / (2*r)); (512*count + r) * recip >> 19 gives round(256*count/r)
    function automatic logic [RECIP_W-1:0] gf_recip(input logic [FF_W-1:0] r);
        logic [RECIP_W-1:0] m;
        case (r)
            4'd1:    m = 19'd262144;
            4'd2:    m = 19'd131072;
            4'd3:    m = 19'd87382;
            4'd4:    m = 19'd65536;
            4'd5:    m = 19'd52429;
            4'd6:    m = 19'd43691;
            4'd7:    m = 19'd37450;
            4'd8:    m = 19'd32768;
            4'd9:    m = 19'd29128;
            4'd10:   m = 19'd26215;
            4'd11:   m = 19'd23832;
            4'd12:   m = 19'd21846;
            4'd13:   m = 19'd20165;
            4'd14:   m = 19'd18725;
            4'd15:   m = 19'd17477;
            default: m = 19'd0;
        endcase
        return m;
    endfunction

endpackage

// ----- rtl/aliasing_fold_overlap_map.sv -----
// Aliasing fold overlap map: top level, mask store in one afom_ram instance.
// Depends on afom_pkg and afom_ram.
//
//  channel   | dir | words                     | fields (lowest bit up)
//  s_axis    | in  | load sample / emit voxel  | tdata: sample; tuser: opcode
//  m_axis    | out | one overlap voxel         | tdata: in_mask, count, gfactor_q8
//  i_cfg_*   | in  | register write            | index, data
//
// Load word: accept, then RAM write. Emit word: accept, R mask reads one per cycle
// (one read outside a fold), registered read data, multiply, output.
// After reset and after any register write other than the cutoff, the next word first
// passes the plane, total and clamp steps and then a shared bit-serial divider.
// The output register holds a word while m_axis_tready is low; a later emit word
// waits for it. The mask store is not cleared by reset.
module aliasing_fold_overlap_map #(
    parameter int MAX_X    = 128,
    parameter int MAX_Y    = 128,
    parameter int MAX_Z    = 64,
    parameter int MAX_FOLD = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [afom_pkg::CFG_AW-1:0]     i_cfg_addr,
    input  logic [afom_pkg::CFG_DW-1:0]     i_cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [afom_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // sample[15:0]
    input  logic                            s_axis_tuser,  // opcode
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // in_mask[0], overlap_count[4:1], gfactor_q8[13:5], zero[15:14]
    output logic [afom_pkg::OT_DATA_W-1:0]  m_axis_tdata,
    output logic                            m_axis_tlast   // last_voxel
);
    import afom_pkg::*;

    localparam int DEPTH = MAX_X * MAX_Y * MAX_Z;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TW    = (AW + 1 > TOT_W) ? AW + 1 : TOT_W;
    localparam int DW    = (AW > 8) ? AW : 8;
    localparam int DCW   = $clog2(DW + 1);
    localparam int PW    = (AW > 24) ? AW : 24;

    // configuration
    logic [CUT_W-1:0] r_cutoff;
    logic [FF_W-1:0]  r_fold;
    t_axis            r_axis;
    logic [EX_W-1:0]  r_ext_x;
    logic [EY_W-1:0]  r_ext_y;
    logic [EZ_W-1:0]  r_ext_z;
    logic             r_stale, n_stale;

    // control
    t_state           r_state, n_state;
    logic [AW-1:0]    r_load_p, n_load_p;
    logic [AW-1:0]    r_emit_p, n_emit_p;
    logic [EX_W-1:0]  r_x, n_x;
    logic [EY_W-1:0]  r_y, n_y;
    logic [EZ_W-1:0]  r_z, n_z;
    logic [7:0]       r_k, n_k;
    logic [7:0]       r_off, n_off;
    logic             r_rd_pend, n_rd_pend;
    logic             r_own_pend, n_own_pend;
    logic             r_out_valid, n_out_valid;

    // payload
    logic [PLANE_W-1:0] r_plane, n_plane;
    logic [TW-1:0]      r_total, n_total;
    logic [AW-1:0]      r_segstep, n_segstep;
    logic [7:0]         r_len, n_len;
    logic [DW-1:0]      r_dvd, n_dvd;
    logic [7:0]         r_rem, n_rem;
    logic [7:0]         r_dvs, n_dvs;
    logic [DCW-1:0]     r_dcnt, n_dcnt;
    logic               r_op, n_op;
    logic               r_bit, n_bit;
    logic               r_isfold, n_isfold;
    logic               r_own, n_own;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [FF_W-1:0]    r_seg_up, n_seg_up;
    logic [FF_W-1:0]    r_seg_dn, n_seg_dn;
    logic [AW-1:0]      r_addr_up, n_addr_up;
    logic [AW-1:0]      r_addr_dn, n_addr_dn;
    logic [PROD_W-1:0]  r_prod, n_prod;
    logic               r_out_mask, n_out_mask;
    logic [CNT_W-1:0]   r_out_count, n_out_count;
    logic [GF_W-1:0]    r_out_gf, n_out_gf;
    logic               r_out_last, n_out_last;

    // derived
    logic [EX_W-1:0]  ex_c;
    logic [EY_W-1:0]  ey_c;
    logic [EZ_W-1:0]  ez_c;
    logic [FF_W-1:0]  r_c;
    logic [7:0]       ax_c;
    logic [7:0]       ax_e;
    logic [PW-1:0]    stride;
    logic [PW-1:0]    seg_prod;
    logic [8:0]       div_sh;
    logic             div_ge;
    logic [8:0]       div_diff;
    logic [7:0]       div_rem_nx;
    logic [DW-1:0]    div_dvd_nx;
    logic             div_run;
    logic [TW-1:0]    emit_inc;
    logic [TW-1:0]    load_inc;
    logic             last_now;
    logic             fold_now;
    logic             can_up;
    logic             can_dn;
    logic [GN_W-1:0]  gn;
    logic             xw, yw, c_step, c_wrap;
    logic             in_fire;
    logic             out_load;

    // memory port
    logic             mem_we;
    logic [AW-1:0]    mem_raddr;
    logic             mem_rdata;

    afom_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_mask_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_load_p),
        .i_wdata (r_bit),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // clamp registers to their legal ranges
    assign ex_c = (r_ext_x == '0) ? EX_W'(1) :
                  ((int'(r_ext_x) > MAX_X) ? EX_W'(MAX_X) : r_ext_x);
    assign ey_c = (r_ext_y == '0) ? EY_W'(1) :
                  ((int'(r_ext_y) > MAX_Y) ? EY_W'(MAX_Y) : r_ext_y);
    assign ez_c = (r_ext_z == '0) ? EZ_W'(1) :
                  ((int'(r_ext_z) > MAX_Z) ? EZ_W'(MAX_Z) : r_ext_z);
    assign r_c  = (r_fold == '0) ? FF_W'(1) :
                  ((int'(r_fold) > MAX_FOLD) ? FF_W'(MAX_FOLD) : r_fold);

    always_comb begin
        case (r_axis)
            AXIS_X:  begin ax_c = r_x;           ax_e = ex_c;           end
            AXIS_Y:  begin ax_c = r_y;           ax_e = ey_c;           end
            AXIS_Z:  begin ax_c = {1'b0, r_z};   ax_e = {1'b0, ez_c};   end
            default: begin ax_c = 8'd0;          ax_e = ex_c;           end
        endcase
    end

    always_comb begin
        case (r_axis)
            AXIS_X:  stride = PW'(1);
            AXIS_Y:  stride = PW'(ex_c);
            AXIS_Z:  stride = PW'(r_plane);
            default: stride = '0;
        endcase
    end

    assign seg_prod = PW'(r_len) * stride;

    // one restoring division step per cycle; quotient shifts into r_dvd
    assign div_sh     = {r_rem, r_dvd[DW-1]};
    assign div_ge     = div_sh >= {1'b0, r_dvs};
    assign div_diff   = div_sh - {1'b0, r_dvs};
    assign div_rem_nx = div_ge ? div_diff[7:0] : div_sh[7:0];
    assign div_dvd_nx = {r_dvd[DW-2:0], div_ge};
    assign div_run    = (r_state inside {S_DIVX, S_DIVY, S_DIVL, S_DIVC}) && (r_dcnt != '0);

    assign emit_inc = TW'(r_emit_p) + TW'(1);
    assign load_inc = TW'(r_load_p) + TW'(1);
    assign last_now = emit_inc == r_total;
    assign fold_now = (r_axis != AXIS_NONE) && (r_len != '0) && (r_k < {4'b0, r_c});
    assign can_up   = r_isfold && (({1'b0, r_seg_up} + 5'd1) < {1'b0, r_c});
    assign can_dn   = r_isfold && (r_seg_dn != '0);
    assign gn       = {r_count, 9'd0} + GN_W'(r_c);

    // raster advance of the emit coordinates
    assign xw = ({1'b0, r_x} + 9'd1) == {1'b0, ex_c};
    assign yw = ({1'b0, r_y} + 9'd1) == {1'b0, ey_c};
    always_comb begin
        case (r_axis)
            AXIS_X:  begin c_step = 1'b1;     c_wrap = xw;        end
            AXIS_Y:  begin c_step = xw;       c_wrap = xw && yw;  end
            AXIS_Z:  begin c_step = xw && yw; c_wrap = 1'b0;      end
            default: begin c_step = 1'b0;     c_wrap = 1'b0;      end
        endcase
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_load      = (r_state == S_OUT) && (!r_out_valid || m_axis_tready);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (in_fire) begin
                n_state = r_stale ? S_PLANE : S_EXEC;
            end
            S_PLANE: n_state = S_TOTAL;
            S_TOTAL: n_state = S_CLAMP;
            S_CLAMP: n_state = S_DIVX;
            S_DIVX:  if (r_dcnt == '0) begin
                n_state = S_DIVY;
            end
            S_DIVY:  if (r_dcnt == '0) begin
                n_state = S_DIVL;
            end
            S_DIVL:  if (r_dcnt == '0) begin
                n_state = S_SEG;
            end
            S_SEG:   n_state = S_DIVC;
            S_DIVC:  if (r_dcnt == '0) begin
                n_state = S_EXEC;
            end
            S_EXEC:  n_state = (r_op == OP_LOAD) ? S_IDLE : S_READ;
            S_READ:  if (!can_up && !can_dn && !r_rd_pend) begin
                n_state = S_GF;
            end
            S_GF:    n_state = S_OUT;
            S_OUT:   if (out_load) begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_stale     = r_stale;
        n_load_p    = r_load_p;
        n_emit_p    = r_emit_p;
        n_x         = r_x;
        n_y         = r_y;
        n_z         = r_z;
        n_k         = r_k;
        n_off       = r_off;
        n_rd_pend   = 1'b0;
        n_own_pend  = r_own_pend;
        n_plane     = r_plane;
        n_total     = r_total;
        n_segstep   = r_segstep;
        n_len       = r_len;
        n_dvd       = r_dvd;
        n_rem       = r_rem;
        n_dvs       = r_dvs;
        n_dcnt      = r_dcnt;
        n_op        = r_op;
        n_bit       = r_bit;
        n_isfold    = r_isfold;
        n_own       = r_own;
        n_count     = r_count;
        n_seg_up    = r_seg_up;
        n_seg_dn    = r_seg_dn;
        n_addr_up   = r_addr_up;
        n_addr_dn   = r_addr_dn;
        n_prod      = r_prod;
        n_out_mask  = r_out_mask;
        n_out_count = r_out_count;
        n_out_gf    = r_out_gf;
        n_out_last  = r_out_last;
        n_out_valid = r_out_valid && !m_axis_tready;
        mem_we      = 1'b0;
        mem_raddr   = r_emit_p;

        if (div_run) begin
            n_dvd  = div_dvd_nx;
            n_rem  = div_rem_nx;
            n_dcnt = r_dcnt - DCW'(1);
        end

        case (r_state)
            S_IDLE: if (in_fire) begin
                n_op  = s_axis_tuser;
                n_bit = s_axis_tdata >= r_cutoff;
            end
            S_PLANE: n_plane = PLANE_W'(ex_c) * PLANE_W'(ey_c);
            S_TOTAL: n_total = TW'(TOT_W'(r_plane) * TOT_W'(ez_c));
            S_CLAMP: begin
                // a position left beyond a shrunken volume restarts at zero
                if (TW'(r_load_p) >= r_total) begin
                    n_load_p = '0;
                end
                if (TW'(r_emit_p) >= r_total) begin
                    n_emit_p = '0;
                    n_dvd    = '0;
                end else begin
                    n_dvd    = DW'(r_emit_p);
                end
                n_rem  = '0;
                n_dvs  = ex_c;
                n_dcnt = DCW'(DW);
            end
            S_DIVX: if (r_dcnt == '0) begin
                n_x    = r_rem;
                n_rem  = '0;
                n_dvs  = ey_c;
                n_dcnt = DCW'(DW);
            end
            S_DIVY: if (r_dcnt == '0) begin
                n_y    = r_rem;
                n_z    = r_dvd[EZ_W-1:0];
                n_dvd  = DW'(ax_e);
                n_rem  = '0;
                n_dvs  = {4'b0, r_c};
                n_dcnt = DCW'(DW);
            end
            S_DIVL: if (r_dcnt == '0) begin
                n_len = r_dvd[7:0];
            end
            S_SEG: begin
                n_segstep = seg_prod[AW-1:0];
                n_dvd     = DW'(ax_c);
                n_rem     = '0;
                n_dvs     = r_len;
                n_dcnt    = DCW'(DW);
            end
            S_DIVC: if (r_dcnt == '0) begin
                // segment index and offset of the axis coordinate
                n_k     = r_dvd[7:0];
                n_off   = r_rem;
                n_stale = 1'b0;
            end
            S_EXEC: begin
                if (r_op == OP_LOAD) begin
                    mem_we   = 1'b1;
                    n_load_p = (load_inc >= r_total) ? '0 : r_load_p + AW'(1);
                end else begin
                    mem_raddr  = r_emit_p;
                    n_rd_pend  = 1'b1;
                    n_own_pend = 1'b1;
                    n_isfold   = fold_now;
                    n_own      = 1'b0;
                    n_count    = '0;
                    n_seg_up   = r_k[FF_W-1:0];
                    n_seg_dn   = r_k[FF_W-1:0];
                    n_addr_up  = r_emit_p;
                    n_addr_dn  = r_emit_p;
                end
            end
            S_READ: begin
                if (r_rd_pend) begin
                    n_own_pend = 1'b0;
                    if (r_own_pend) begin
                        n_own = mem_rdata;
                    end
                    if (r_isfold) begin
                        n_count = r_count + CNT_W'(mem_rdata);
                    end
                end
                // walk up to the last segment, then down to the first
                if (can_up) begin
                    mem_raddr = r_addr_up + r_segstep;
                    n_addr_up = r_addr_up + r_segstep;
                    n_seg_up  = r_seg_up + FF_W'(1);
                    n_rd_pend = 1'b1;
                end else if (can_dn) begin
                    mem_raddr = r_addr_dn - r_segstep;
                    n_addr_dn = r_addr_dn - r_segstep;
                    n_seg_dn  = r_seg_dn - FF_W'(1);
                    n_rd_pend = 1'b1;
                end
            end
            S_GF: n_prod = PROD_W'(gn) * PROD_W'(gf_recip(r_c));
            S_OUT: if (out_load) begin
                n_out_valid = 1'b1;
                n_out_mask  = (r_isfold || r_axis == AXIS_NONE) ? r_own : 1'b0;
                n_out_count = r_isfold ? r_count : '0;
                n_out_gf    = (r_isfold && r_own) ? r_prod[RECIP_SH +: GF_W] : '0;
                n_out_last  = last_now;
                if (last_now) begin
                    n_emit_p = '0;
                    n_x      = '0;
                    n_y      = '0;
                    n_z      = '0;
                    n_k      = '0;
                    n_off    = '0;
                end else begin
                    n_emit_p = r_emit_p + AW'(1);
                    n_x      = xw ? '0 : r_x + EX_W'(1);
                    if (xw) begin
                        n_y = yw ? '0 : r_y + EY_W'(1);
                    end
                    if (xw && yw) begin
                        n_z = r_z + EZ_W'(1);
                    end
                    if (c_step) begin
                        if (c_wrap) begin
                            n_k   = '0;
                            n_off = '0;
                        end else if ((r_off + 8'd1) == r_len) begin
                            n_k   = r_k + 8'd1;
                            n_off = '0;
                        end else begin
                            n_off = r_off + 8'd1;
                        end
                    end
                end
            end
            default: ;
        endcase

        if (i_cfg_we && i_cfg_addr != REG_CUTOFF) begin
            n_stale = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_stale     <= 1'b1;
            r_load_p    <= '0;
            r_emit_p    <= '0;
            r_x         <= '0;
            r_y         <= '0;
            r_z         <= '0;
            r_k         <= '0;
            r_off       <= '0;
            r_rd_pend   <= 1'b0;
            r_own_pend  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cutoff    <= '0;
            r_fold      <= FF_W'(2);
            r_axis      <= AXIS_Y;
            r_ext_x     <= EX_W'(128);
            r_ext_y     <= EY_W'(128);
            r_ext_z     <= EZ_W'(64);
        end else begin
            r_state     <= n_state;
            r_stale     <= n_stale;
            r_load_p    <= n_load_p;
            r_emit_p    <= n_emit_p;
            r_x         <= n_x;
            r_y         <= n_y;
            r_z         <= n_z;
            r_k         <= n_k;
            r_off       <= n_off;
            r_rd_pend   <= n_rd_pend;
            r_own_pend  <= n_own_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_CUTOFF: r_cutoff <= i_cfg_data[CUT_W-1:0];
                    REG_FOLD:   r_fold   <= i_cfg_data[FF_W-1:0];
                    REG_AXIS:   r_axis   <= t_axis'(i_cfg_data[AX_W-1:0]);
                    REG_EXT_X:  r_ext_x  <= i_cfg_data[EX_W-1:0];
                    REG_EXT_Y:  r_ext_y  <= i_cfg_data[EY_W-1:0];
                    REG_EXT_Z:  r_ext_z  <= i_cfg_data[EZ_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_plane     <= n_plane;
        r_total     <= n_total;
        r_segstep   <= n_segstep;
        r_len       <= n_len;
        r_dvd       <= n_dvd;
        r_rem       <= n_rem;
        r_dvs       <= n_dvs;
        r_dcnt      <= n_dcnt;
        r_op        <= n_op;
        r_bit       <= n_bit;
        r_isfold    <= n_isfold;
        r_own       <= n_own;
        r_count     <= n_count;
        r_seg_up    <= n_seg_up;
        r_seg_dn    <= n_seg_dn;
        r_addr_up   <= n_addr_up;
        r_addr_dn   <= n_addr_dn;
        r_prod      <= n_prod;
        r_out_mask  <= n_out_mask;
        r_out_count <= n_out_count;
        r_out_gf    <= n_out_gf;
        r_out_last  <= n_out_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{OT_PAD_W{1'b0}}, r_out_gf, r_out_count, r_out_mask};
    assign m_axis_tlast  = r_out_last;

endmodule

// ----- rtl/afom_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module afom_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/afom_checker.sv -----
// Port-level checks for aliasing_fold_overlap_map, attached by bind.
// Depends on afom_pkg for the output word layout.
module afom_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [afom_pkg::OT_DATA_W-1:0]  m_axis_tdata,
    input logic                            m_axis_tlast
);
    import afom_pkg::*;

    // one word at a time: the input is closed in the cycle after an accepted word
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted on back-to-back cycles");

    // a voxel outside the mask carries no g-factor
    a_gf_needs_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[OT_MASK_BIT])
            |-> (m_axis_tdata[OT_GF_LSB +: GF_W] == '0))
        else $error("g-factor set on unmasked voxel");

    // g-factor never exceeds 1.0 and padding stays zero
    a_gf_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((m_axis_tdata[OT_GF_LSB +: GF_W] <= 9'd256)
            && (m_axis_tdata[OT_DATA_W-1 -: OT_PAD_W] == '0)))
        else $error("g-factor out of range or padding set");

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready)
            |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("output word changed while stalled");

endmodule

bind aliasing_fold_overlap_map afom_checker u_afom_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// ----- tb/aliasing_fold_overlap_map_test.sv -----
// Self-checking testbench for aliasing_fold_overlap_map: stream driver, monitor,
// and a cycle-free predictor of the mask store and the folded overlap counts.
// Depends on afom_pkg and the RTL of the block; reads no files.
module aliasing_fold_overlap_map_test;
    import afom_pkg::*;

    localparam int MAXX        = 128;
    localparam int MAXY        = 128;
    localparam int MAXZ        = 64;
    localparam int MAXR        = 8;
    localparam int DEPTH       = MAXX * MAXY * MAXZ;
    localparam int SETTLE      = 120;
    localparam int LONG_HOLD   = 400;
    localparam int WATCH_LIMIT = 3000;
    localparam int RAND_WORDS  = 1600;

    typedef struct packed {
        logic             op;
        logic [SAMP_W-1:0] samp;
    } t_word;

    typedef struct packed {
        logic            in_mask;
        logic [CNT_W-1:0] count;
        logic [GF_W-1:0]  gf;
        logic            last;
    } t_voxel;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_AW-1:0]    i_cfg_addr = '0;
    logic [CFG_DW-1:0]    i_cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata = '0;
    logic                 s_axis_tuser = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OT_DATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tlast;

    aliasing_fold_overlap_map uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),   // sample[15:0]
        .s_axis_tuser (s_axis_tuser),   // opcode
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),   // in_mask, overlap_count, gfactor_q8, zero pad
        .m_axis_tlast (m_axis_tlast)    // last_voxel
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // predictor state: mask store, positions and a copy of the registers
    bit                mask_bits [DEPTH];
    int unsigned       load_pos = 0;
    int unsigned       emit_pos = 0;
    logic [CUT_W-1:0]  cut_lvl = '0;
    logic [FF_W-1:0]   fold_r = 4'd2;
    t_axis             fold_ax = AXIS_Y;
    logic [EX_W-1:0]   ext_x = 8'd128;
    logic [EY_W-1:0]   ext_y = 8'd128;
    logic [EZ_W-1:0]   ext_z = 7'd64;

    t_voxel expected_voxels[$];
    t_word  pending_words[$];

    int  words_queued = 0;
    int  words_in = 0;
    int  voxels_out = 0;
    int  mismatches = 0;
    int  settings = 0;
    int  idle_cycles = 0;
    bit  in_fire = 1'b0;
    bit  out_fire = 1'b0;
    bit  tx_burst = 1'b0;
    bit  rx_burst = 1'b0;
    bit  hold_req = 1'b0;
    bit  hold_taken = 1'b0;
    int  tx_gap = 0;
    int  rx_wait = 0;
    int  hold_left = 0;
    t_word tx_word;

    function automatic int unsigned clamp_ext(int unsigned v, int unsigned hi);
        if (v == 0) return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic int unsigned volume_voxels();
        return clamp_ext(ext_x, MAXX) * clamp_ext(ext_y, MAXY) * clamp_ext(ext_z, MAXZ);
    endfunction

    // apply one accepted word to the predictor; an emit queues its voxel
    function automatic void absorb_word(logic op, logic [SAMP_W-1:0] samp);
        int unsigned ex, ey, ez, total, r, p, x, y, z, c, e, stride, len, base, off, cnt;
        t_voxel v;
        ex = clamp_ext(ext_x, MAXX);
        ey = clamp_ext(ext_y, MAXY);
        ez = clamp_ext(ext_z, MAXZ);
        total = ex * ey * ez;
        r = clamp_ext(fold_r, MAXR);
        if (op == OP_LOAD) begin
            p = (load_pos < total) ? load_pos : 0;
            mask_bits[p] = (samp >= cut_lvl);
            p++;
            load_pos = (p >= total) ? 0 : p;
            return;
        end
        p = (emit_pos < total) ? emit_pos : 0;
        x = p % ex;
        y = (p / ex) % ey;
        z = p / (ex * ey);
        v = '0;
        cnt = 0;
        if (fold_ax == AXIS_NONE) begin
            v.in_mask = mask_bits[p];
        end else begin
            if (fold_ax == AXIS_X) begin
                c = x; e = ex; stride = 1;
            end else if (fold_ax == AXIS_Y) begin
                c = y; e = ey; stride = ex;
            end else begin
                c = z; e = ez; stride = ex * ey;
            end
            len = e / r;
            // outside the trimmed region everything but the last flag stays zero
            if (len != 0 && c < len * r) begin
                base = p - c * stride;
                off = c % len;
                for (int s = 0; s < r; s++)
                    cnt += mask_bits[base + (off + s * len) * stride];
                v.in_mask = mask_bits[p];
                v.count = CNT_W'(cnt);
                if (v.in_mask)
                    v.gf = GF_W'((512 * cnt + r) / (2 * r));
            end
        end
        v.last = (p + 1 == total);
        p++;
        emit_pos = (p >= total) ? 0 : p;
        expected_voxels.push_back(v);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("voxel %0d: %s got %0d want %0d", voxels_out, what, got, want);
        mismatches++;
    endtask

    task automatic check_voxel();
        t_voxel want;
        if (expected_voxels.size() == 0) begin
            report_mismatch("unexpected word, tdata", m_axis_tdata, 0);
        end else begin
            want = expected_voxels.pop_front();
            if (m_axis_tdata[OT_MASK_BIT] !== want.in_mask)
                report_mismatch("in_mask", m_axis_tdata[OT_MASK_BIT], want.in_mask);
            if (m_axis_tdata[OT_CNT_LSB +: CNT_W] !== want.count)
                report_mismatch("overlap_count", m_axis_tdata[OT_CNT_LSB +: CNT_W], want.count);
            if (m_axis_tdata[OT_GF_LSB +: GF_W] !== want.gf)
                report_mismatch("gfactor_q8", m_axis_tdata[OT_GF_LSB +: GF_W], want.gf);
            if (m_axis_tlast !== want.last)
                report_mismatch("last_voxel", m_axis_tlast, want.last);
        end
        voxels_out++;
    endtask

    // monitor: sample both handshakes at the rising edge
    always @(posedge i_clk) begin
        in_fire  <= i_rst_n && s_axis_tvalid && s_axis_tready;
        out_fire <= i_rst_n && m_axis_tvalid && m_axis_tready;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            absorb_word(s_axis_tuser, s_axis_tdata);
            words_in++;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            check_voxel();
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCH_LIMIT) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("[aliasing_fold_overlap_map] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int draw_gap(bit burst);
        if (burst || $urandom_range(0, 3) == 0) return 0;
        return $urandom_range(0, 11);
    endfunction

    // driver: hold the word until taken, then wait out its gap
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_fire) begin
            if (tx_gap > 0) begin
                tx_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_words.size() > 0) begin
                tx_word = pending_words.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= tx_word.samp;
                s_axis_tuser  <= tx_word.op;
                tx_gap = draw_gap(tx_burst);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: a random stall, possibly none, after each word, plus one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = LONG_HOLD;
        end
        if (out_fire)
            rx_wait = draw_gap(rx_burst);
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (rx_wait > 0) begin
            rx_wait--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic wait_drained();
        while (words_in != words_queued || expected_voxels.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        case (idx)
            REG_CUTOFF: cut_lvl = val[CUT_W-1:0];
            REG_FOLD:   fold_r = val[FF_W-1:0];
            REG_AXIS:   fold_ax = t_axis'(val[AX_W-1:0]);
            REG_EXT_X:  ext_x = val[EX_W-1:0];
            REG_EXT_Y:  ext_y = val[EY_W-1:0];
            REG_EXT_Z:  ext_z = val[EZ_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // reprogram only once the block has gone quiet
    task automatic set_geometry(logic [CUT_W-1:0] cut, logic [FF_W-1:0] r, t_axis ax,
                                logic [EX_W-1:0] ex, logic [EY_W-1:0] ey,
                                logic [EZ_W-1:0] ez);
        wait_drained();
        repeat (SETTLE) @(negedge i_clk);
        write_reg(REG_CUTOFF, CFG_DW'(cut));
        write_reg(REG_FOLD, CFG_DW'(r));
        write_reg(REG_AXIS, CFG_DW'(ax));
        write_reg(REG_EXT_X, CFG_DW'(ex));
        write_reg(REG_EXT_Y, CFG_DW'(ey));
        write_reg(REG_EXT_Z, CFG_DW'(ez));
        settings++;
    endtask

    task automatic queue_word(logic op, logic [SAMP_W-1:0] samp);
        t_word w;
        w.op = op;
        w.samp = samp;
        pending_words.push_back(w);
        words_queued++;
    endtask

    function automatic logic [SAMP_W-1:0] draw_sample();
        case ($urandom_range(0, 3))
            0:       return cut_lvl;
            1:       return cut_lvl - 1'b1;
            default: return SAMP_W'($urandom);
        endcase
    endfunction

    // a full load first, so every voxel an emit can touch has been written
    task automatic queue_volume(int n_mix);
        int unsigned total;
        total = volume_voxels();
        for (int i = 0; i < total; i++)
            queue_word(OP_LOAD, draw_sample());
        for (int i = 0; i < n_mix; i++) begin
            if ($urandom_range(0, 3) != 0)
                queue_word(OP_EMIT, SAMP_W'($urandom));
            else
                queue_word(OP_LOAD, draw_sample());
        end
    endtask

    initial begin
        int directed_words;
        t_axis ax;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // 2x4x1 volume folded twice along y, samples around the cutoff
        set_geometry(16'h8000, 4'd2, AXIS_Y, 8'd2, 8'd4, 7'd1);
        queue_word(OP_LOAD, 16'h0000);
        queue_word(OP_LOAD, 16'hFFFF);
        queue_word(OP_LOAD, 16'h7FFF);
        queue_word(OP_LOAD, 16'h8000);
        queue_word(OP_LOAD, 16'hFFFF);
        queue_word(OP_LOAD, 16'h0001);
        queue_word(OP_LOAD, 16'h8001);
        queue_word(OP_LOAD, 16'hAAAA);
        // run past the last voxel to see the emit position wrap
        for (int i = 0; i < 10; i++)
            queue_word(OP_EMIT, 16'h5555);
        directed_words = words_queued;

        // oversized extent and fold factor saturate; full overlap everywhere
        set_geometry(16'h0000, 4'd15, AXIS_X, 8'd255, 8'd0, 7'd0);
        queue_volume(40);
        set_geometry(16'hFFFF, 4'd7, AXIS_Y, 8'd1, 8'd128, 7'd1);
        queue_volume(40);
        set_geometry(16'($urandom), 4'd0, AXIS_Z, 8'd1, 8'd1, 7'd127);
        queue_volume(40);
        // fold factor above the axis extent: nothing survives trimming
        set_geometry(16'($urandom), 4'd8, AXIS_Y, 8'd3, 8'd2, 7'd2);
        queue_volume(20);
        set_geometry(16'($urandom), 4'd3, AXIS_NONE, 8'd4, 8'd3, 7'd2);
        queue_volume(30);

        // back-to-back sender against a long receiver hold-off
        set_geometry(16'($urandom), 4'd4, AXIS_Z, 8'd4, 8'd4, 7'd4);
        tx_burst = 1'b1;
        hold_req = 1'b1;
        queue_volume(80);

        while (words_queued - directed_words < RAND_WORDS) begin
            ax = t_axis'($urandom_range(0, 3));
            set_geometry(($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom),
                         ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                                     : 4'($urandom_range(1, 6)),
                         ax, 8'($urandom_range(0, 6)), 8'($urandom_range(1, 6)),
                         7'($urandom_range(1, 3)));
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            queue_volume($urandom_range(20, 90));
        end

        wait_drained();
        repeat (SETTLE) @(negedge i_clk);
        $display("sent %0d words, checked %0d voxels across %0d register settings",
                 words_in, voxels_out, settings);
        $display("covered all axes, fold factors 0..15, trimmed and saturated extents");
        if (mismatches == 0 && expected_voxels.size() == 0) begin
            $display("[aliasing_fold_overlap_map] OK");
        end else begin
            $display("%0d mismatches, %0d voxels outstanding", mismatches,
                     expected_voxels.size());
            $display("[aliasing_fold_overlap_map] ERROR");
        end
        $finish;
    end

endmodule
